// ===== design/sparse_triplet_transpose_core_assert.svh =====
// Assertion macros used by the checker of the sparse triplet transpose core.
`ifndef SPARSE_TRIPLET_TRANSPOSE_CORE_ASSERT_SVH
`define SPARSE_TRIPLET_TRANSPOSE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stt: next-cycle check failed");

`endif

// ===== design/stt_pkg.sv =====
// Package of the sparse triplet transpose core: widths, register indexes and sequencer states.
package stt_pkg;

    localparam int IDX_W      = 9;
    localparam int VAL_W      = 32;
    localparam int FIELD_W    = 2 * IDX_W + VAL_W;
    localparam int DATA_W     = ((FIELD_W + 7) / 8) * 8;
    localparam int PAD_W      = DATA_W - FIELD_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int MAX_TERMS_DEF  = 64;
    localparam int MAX_DIM_DEF    = 256;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [CFG_IDX_W-1:0]  REG_NUM_ROWS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_NUM_COLS     = 2'd1;
    localparam logic [CFG_DATA_W-1:0] NUM_COLS_RESET   = 9'd256;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_COUNT,
        S_SUM,
        S_SC_RD,
        S_SC_ST,
        S_SC_WR,
        S_EM_RD,
        S_EM_LD,
        S_EM_WAIT
    } state_t;

endpackage

// ===== design/sparse_triplet_transpose_core.sv =====
// Sparse matrix transpose over a stream of (row, column, value) words, counting-sort form.
//
// Input words arrive on s_tvalid/s_tready/s_tdata with s_tlast on the final term of a
// matrix. Each stored term is written to the store and then its column count is updated;
// a dropped term (column zero, above num_cols or MAX_DIM, or store full) sets the drop
// flag. s_tready is low while a matrix is being transposed.
// After the marked term of a non-empty matrix the sequencer runs a prefix sum over the
// column count memory, which also zeroes the counts, then scatters each stored term
// into its output slot, then emits the transposed words in column-major order on
// m_tvalid/m_tready/m_tdata, m_tlast on the final one and the drop flag on m_tuser.
// An empty matrix gives one marker word with zero fields and m_tlast set. The sequencer
// reuses the one read port and the one write port of each memory for every step.
// A stalled receiver holds the output word in its register; nothing else moves.
// After reset the count memory is cleared, one entry per cycle, before s_tready rises.
// Configuration writes are taken at any time.
module sparse_triplet_transpose_core #(
    parameter int MAX_TERMS  = stt_pkg::MAX_TERMS_DEF,
    parameter int MAX_DIM    = stt_pkg::MAX_DIM_DEF,
    parameter int VALUE_BITS = stt_pkg::VALUE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [stt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [stt_pkg::DATA_W-1:0]     s_tdata,   // row_index, col_index, term_value
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [stt_pkg::DATA_W-1:0]     m_tdata,   // out_row, out_col, out_value
    output logic                           m_tlast,
    output logic                           m_tuser    // dropped
);

    localparam int IW      = stt_pkg::IDX_W;
    localparam int DIM_AW  = $clog2(MAX_DIM);
    localparam int DIM_CW  = $clog2(MAX_DIM + 1);
    localparam int IDXW    = (DIM_CW > IW) ? DIM_CW : IW;
    localparam int TERM_AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W   = $clog2(MAX_TERMS + 1);
    localparam int TERM_W  = 2 * IW + VALUE_BITS;

    // Memories
    logic [TERM_W-1:0] term_mem  [MAX_TERMS];
    logic [TERM_W-1:0] slot_mem  [MAX_TERMS];
    logic [CNT_W-1:0]  count_mem [MAX_DIM];
    logic [CNT_W-1:0]  start_mem [MAX_DIM];

    logic [TERM_W-1:0] term_q;
    logic [TERM_W-1:0] slot_q;
    logic [CNT_W-1:0]  count_q;
    logic [CNT_W-1:0]  start_q;

    logic               term_we, term_re;
    logic [TERM_AW-1:0] term_wa, term_ra;
    logic               slot_we, slot_re;
    logic [TERM_AW-1:0] slot_wa, slot_ra;
    logic               count_we, count_re;
    logic [DIM_AW-1:0]  count_wa, count_ra;
    logic [CNT_W-1:0]   count_wd;
    logic               start_we, start_re;
    logic [DIM_AW-1:0]  start_wa, start_ra;
    logic [CNT_W-1:0]   start_wd;

    // Control registers
    stt_pkg::state_t    state_reg, state_next;
    logic [IW-1:0]      num_cols_reg;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic               drop_reg, drop_next;
    logic [DIM_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [DIM_CW-1:0]  sum_cnt_reg, sum_cnt_next;
    logic               sum_pend_reg, sum_pend_next;
    logic [DIM_AW-1:0]  sum_wa_reg, sum_wa_next;
    logic [CNT_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [DIM_AW-1:0]  cnt_wa_reg, cnt_wa_next;
    logic               last_reg, last_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // Output payload registers
    logic [IW-1:0]             out_row_reg, out_row_next;
    logic [IW-1:0]             out_col_reg, out_col_next;
    logic [stt_pkg::VAL_W-1:0] out_val_reg, out_val_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_drop_reg, out_drop_next;

    // Input decode
    logic [IW-1:0]             in_row, in_col;
    logic [stt_pkg::VAL_W-1:0] in_val;
    logic [IDXW-1:0]           in_col_ext;
    logic [DIM_AW-1:0]         in_addr;
    logic                      take, col_ok, full, store_ok;

    // Stored term decode
    logic [IW-1:0]         t_col;
    logic [DIM_AW-1:0]     t_addr;
    logic [IW-1:0]         s_row, s_col;
    logic [VALUE_BITS-1:0] s_val;
    logic [CNT_W-1:0]      ptr_inc;
    logic                  sum_done;

    assign in_row     = s_tdata[IW-1:0];
    assign in_col     = s_tdata[2*IW-1:IW];
    assign in_val     = s_tdata[stt_pkg::FIELD_W-1:2*IW];
    assign in_col_ext = IDXW'(in_col);
    assign in_addr    = DIM_AW'(in_col_ext - IDXW'(1));

    assign s_tready = (state_reg == stt_pkg::S_IDLE);
    assign take     = s_tvalid && s_tready;
    assign col_ok   = (in_col != '0) && (in_col <= num_cols_reg)
                      && (in_col_ext <= IDXW'(MAX_DIM));
    assign full     = (total_reg == CNT_W'(MAX_TERMS));
    assign store_ok = col_ok && !full;

    assign t_col  = term_q[2*IW-1:IW];
    assign t_addr = DIM_AW'(IDXW'(t_col) - IDXW'(1));
    assign s_row  = slot_q[IW-1:0];
    assign s_col  = slot_q[2*IW-1:IW];
    assign s_val  = slot_q[TERM_W-1:2*IW];

    assign ptr_inc  = ptr_reg + CNT_W'(1);
    assign sum_done = (sum_cnt_reg == DIM_CW'(MAX_DIM));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stt_pkg::S_CLEAR:
            begin
                if (clr_cnt_reg == DIM_AW'(MAX_DIM - 1))
                    state_next = stt_pkg::S_IDLE;
            end
            stt_pkg::S_IDLE:
            begin
                if (take)
                begin
                    if (store_ok)
                        state_next = stt_pkg::S_COUNT;
                    else if (s_tlast)
                        state_next = (total_reg == '0) ? stt_pkg::S_EM_LD : stt_pkg::S_SUM;
                end
            end
            stt_pkg::S_COUNT:
            begin
                state_next = last_reg ? stt_pkg::S_SUM : stt_pkg::S_IDLE;
            end
            stt_pkg::S_SUM:
            begin
                if (sum_done && !sum_pend_reg)
                    state_next = stt_pkg::S_SC_RD;
            end
            stt_pkg::S_SC_RD:
                state_next = stt_pkg::S_SC_ST;
            stt_pkg::S_SC_ST:
                state_next = stt_pkg::S_SC_WR;
            stt_pkg::S_SC_WR:
            begin
                state_next = (ptr_inc == total_reg) ? stt_pkg::S_EM_RD : stt_pkg::S_SC_RD;
            end
            stt_pkg::S_EM_RD:
                state_next = stt_pkg::S_EM_LD;
            stt_pkg::S_EM_LD:
                state_next = stt_pkg::S_EM_WAIT;
            stt_pkg::S_EM_WAIT:
            begin
                if (m_tready)
                    state_next = out_last_reg ? stt_pkg::S_IDLE : stt_pkg::S_EM_RD;
            end
            default:
                state_next = stt_pkg::S_CLEAR;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        term_we  = 1'b0;
        term_re  = 1'b0;
        term_wa  = total_reg[TERM_AW-1:0];
        term_ra  = ptr_reg[TERM_AW-1:0];
        slot_we  = 1'b0;
        slot_re  = 1'b0;
        slot_wa  = start_q[TERM_AW-1:0];
        slot_ra  = ptr_reg[TERM_AW-1:0];
        count_we = 1'b0;
        count_re = 1'b0;
        count_wa = clr_cnt_reg;
        count_ra = in_addr;
        count_wd = '0;
        start_we = 1'b0;
        start_re = 1'b0;
        start_wa = sum_wa_reg;
        start_ra = t_addr;
        start_wd = acc_reg;

        total_next    = total_reg;
        drop_next     = drop_reg;
        clr_cnt_next  = clr_cnt_reg;
        sum_cnt_next  = sum_cnt_reg;
        sum_pend_next = sum_pend_reg;
        sum_wa_next   = sum_wa_reg;
        acc_next      = acc_reg;
        ptr_next      = ptr_reg;
        cnt_wa_next   = cnt_wa_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tvalid_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_val_next  = out_val_reg;
        out_last_next = out_last_reg;
        out_drop_next = out_drop_reg;

        case (state_reg)
            stt_pkg::S_CLEAR:
            begin
                count_we     = 1'b1;
                clr_cnt_next = clr_cnt_reg + DIM_AW'(1);
            end
            stt_pkg::S_IDLE:
            begin
                sum_cnt_next  = '0;
                sum_pend_next = 1'b0;
                acc_next      = '0;
                if (take)
                begin
                    if (store_ok)
                    begin
                        term_we     = 1'b1;
                        count_re    = 1'b1;
                        total_next  = total_reg + CNT_W'(1);
                        cnt_wa_next = in_addr;
                        last_next   = s_tlast;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
            end
            stt_pkg::S_COUNT:
            begin
                count_we = 1'b1;
                count_wa = cnt_wa_reg;
                count_wd = count_q + CNT_W'(1);
            end
            stt_pkg::S_SUM:
            begin
                // Reads run one column ahead of the start writes.
                if (!sum_done)
                begin
                    count_re      = 1'b1;
                    count_ra      = sum_cnt_reg[DIM_AW-1:0];
                    sum_cnt_next  = sum_cnt_reg + DIM_CW'(1);
                    sum_wa_next   = sum_cnt_reg[DIM_AW-1:0];
                    sum_pend_next = 1'b1;
                end
                else
                begin
                    sum_pend_next = 1'b0;
                end
                if (sum_pend_reg)
                begin
                    start_we = 1'b1;
                    count_we = 1'b1;
                    count_wa = sum_wa_reg;
                    acc_next = acc_reg + count_q;
                end
            end
            stt_pkg::S_SC_RD:
            begin
                term_re = 1'b1;
            end
            stt_pkg::S_SC_ST:
            begin
                start_re = 1'b1;
            end
            stt_pkg::S_SC_WR:
            begin
                slot_we  = 1'b1;
                start_we = 1'b1;
                start_wa = t_addr;
                start_wd = start_q + CNT_W'(1);
                ptr_next = (ptr_inc == total_reg) ? '0 : ptr_inc;
            end
            stt_pkg::S_EM_RD:
            begin
                slot_re = 1'b1;
            end
            stt_pkg::S_EM_LD:
            begin
                m_tvalid_next = 1'b1;
                out_drop_next = drop_reg;
                if (total_reg == '0)
                begin
                    // Empty matrix: a single marker word.
                    out_row_next  = '0;
                    out_col_next  = '0;
                    out_val_next  = '0;
                    out_last_next = 1'b1;
                end
                else
                begin
                    out_row_next  = s_col;
                    out_col_next  = s_row;
                    out_val_next  = stt_pkg::VAL_W'(s_val);
                    out_last_next = (ptr_inc == total_reg);
                end
            end
            stt_pkg::S_EM_WAIT:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        ptr_next   = '0;
                        total_next = '0;
                        drop_next  = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_inc;
                    end
                end
            end
            default:
            begin
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= stt_pkg::S_CLEAR;
            total_reg    <= '0;
            drop_reg     <= 1'b0;
            clr_cnt_reg  <= '0;
            sum_cnt_reg  <= '0;
            sum_pend_reg <= 1'b0;
            sum_wa_reg   <= '0;
            acc_reg      <= '0;
            ptr_reg      <= '0;
            cnt_wa_reg   <= '0;
            last_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            drop_reg     <= drop_next;
            clr_cnt_reg  <= clr_cnt_next;
            sum_cnt_reg  <= sum_cnt_next;
            sum_pend_reg <= sum_pend_next;
            sum_wa_reg   <= sum_wa_next;
            acc_reg      <= acc_next;
            ptr_reg      <= ptr_next;
            cnt_wa_reg   <= cnt_wa_next;
            last_reg     <= last_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Configuration registers; the row count has no effect on the transpose.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= stt_pkg::NUM_COLS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                stt_pkg::REG_NUM_ROWS: ;
                stt_pkg::REG_NUM_COLS: num_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
    end

    always_ff @(posedge clk)
    begin
        if (term_we)
            term_mem[term_wa] <= {VALUE_BITS'(in_val), in_col, in_row};
        if (term_re)
            term_q <= term_mem[term_ra];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_wa] <= term_q;
        if (slot_re)
            slot_q <= slot_mem[slot_ra];
    end

    always_ff @(posedge clk)
    begin
        if (count_we)
            count_mem[count_wa] <= count_wd;
        if (count_re)
            count_q <= count_mem[count_ra];
    end

    always_ff @(posedge clk)
    begin
        if (start_we)
            start_mem[start_wa] <= start_wd;
        if (start_re)
            start_q <= start_mem[start_ra];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{stt_pkg::PAD_W{1'b0}}, out_val_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_drop_reg;

endmodule

// ===== design/stt_checker.sv =====
// Port-level checks of the sparse triplet transpose core, bound to the core module.
`include "sparse_triplet_transpose_core_assert.svh"

module stt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       s_tlast,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [stt_pkg::DATA_W-1:0] m_tdata,
    input logic                       m_tlast,
    input logic                       m_tuser
);

    // A word waiting at the output holds until it is taken.
    `STT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // Input and output never overlap: a matrix is taken in, then given out.
    `STT_ASSERT_SAME(a_no_overlap, clk, rst_n, m_tvalid, !s_tready)

    // The final input term starts the transpose, so intake stops.
    `STT_ASSERT_NEXT(a_last_stops_input, clk, rst_n, s_tvalid && s_tready && s_tlast, !s_tready)

    // Intake stays closed until the final output word of the matrix is taken.
    `STT_ASSERT_NEXT(a_output_run, clk, rst_n, m_tvalid && m_tready && !m_tlast, !s_tready)

endmodule

bind sparse_triplet_transpose_core stt_checker u_stt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the sparse triplet transpose core with its own transpose predictor.
module testbench;

    localparam int MAX_TERMS      = stt_pkg::MAX_TERMS_DEF;
    localparam int MAX_DIM        = stt_pkg::MAX_DIM_DEF;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef logic [stt_pkg::IDX_W-1:0]      idx_t;
    typedef logic [stt_pkg::VAL_W-1:0]      val_t;
    typedef logic [stt_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [stt_pkg::CFG_DATA_W-1:0] cfg_word_t;

    // Indexes that the block has no register behind; writes to them must be ignored.
    localparam cfg_idx_t REG_SPARE_A = 2'd2;
    localparam cfg_idx_t REG_SPARE_B = 2'd3;

    typedef struct {
        idx_t row;
        idx_t col;
        val_t val;
        logic last;
    } source_term_t;

    typedef struct {
        idx_t row;
        idx_t col;
        val_t val;
        logic last;
        logic dropped;
    } transposed_word_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    cfg_idx_t                   cfg_index = '0;
    cfg_word_t                  cfg_data  = '0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [stt_pkg::DATA_W-1:0] s_tdata   = '0;
    logic                       s_tlast   = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [stt_pkg::DATA_W-1:0] m_tdata;
    logic                       m_tlast;
    logic                       m_tuser;

    source_term_t     pending_terms[$];
    source_term_t     held_terms[$];
    transposed_word_t expected_words[$];

    cfg_word_t num_cols_reg = 9'd256;
    logic      held_drop    = 1'b0;

    int error_count  = 0;
    bit hold_request = 1'b0;

    sparse_triplet_transpose_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Draws the wait before the next word; a side runs in bursts with no wait at all
    // now and then.
    function automatic int draw_gap(ref bit burst);
        if ($urandom_range(0, 15) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 9);
    endfunction

    // Stores an accepted term and, on the marked term, computes the transposed words.
    function automatic void absorb_term(source_term_t t);
        int               col_lim;
        int               placed;
        transposed_word_t w;
        col_lim = (num_cols_reg > MAX_DIM) ? MAX_DIM : int'(num_cols_reg);
        if (t.col == 0 || t.col > col_lim || held_terms.size() >= MAX_TERMS)
            held_drop = 1'b1;
        else
            held_terms.push_back(t);
        if (!t.last)
            return;
        if (held_terms.size() == 0)
        begin
            w.row     = '0;
            w.col     = '0;
            w.val     = '0;
            w.last    = 1'b1;
            w.dropped = held_drop;
            expected_words.push_back(w);
        end
        else
        begin
            placed = 0;
            // Column-major order, arrival order kept within a column.
            for (int c = 1; c <= MAX_DIM; c++)
            begin
                for (int p = 0; p < held_terms.size(); p++)
                begin
                    if (held_terms[p].col == c)
                    begin
                        placed++;
                        w.row     = held_terms[p].col;
                        w.col     = held_terms[p].row;
                        w.val     = held_terms[p].val;
                        w.last    = (placed == held_terms.size());
                        w.dropped = held_drop;
                        expected_words.push_back(w);
                    end
                end
            end
        end
        held_terms.delete();
        held_drop = 1'b0;
    endfunction

    // Sender.
    source_term_t cur_term;
    int           send_gap   = 0;
    bit           send_burst = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                absorb_term(cur_term);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_terms.size() != 0)
                begin
                    cur_term = pending_terms.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{stt_pkg::PAD_W{1'b0}}, cur_term.val, cur_term.col,
                                 cur_term.row};
                    s_tlast  <= cur_term.last;
                    send_gap = draw_gap(send_burst);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver and checker.
    transposed_word_t want;
    idx_t             got_row;
    idx_t             got_col;
    val_t             got_val;
    int               recv_gap   = 0;
    int               hold_left  = 0;
    bit               hold_done  = 1'b0;
    bit               recv_burst = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_row = m_tdata[stt_pkg::IDX_W-1:0];
                got_col = m_tdata[2*stt_pkg::IDX_W-1:stt_pkg::IDX_W];
                got_val = m_tdata[stt_pkg::FIELD_W-1:2*stt_pkg::IDX_W];
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word: row %0d col %0d value %h",
                           got_row, got_col, got_val);
                    error_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got_row !== want.row)
                    begin
                        $error("out_row: expected %0d, actual %0d", want.row, got_row);
                        error_count++;
                    end
                    if (got_col !== want.col)
                    begin
                        $error("out_col: expected %0d, actual %0d", want.col, got_col);
                        error_count++;
                    end
                    if (got_val !== want.val)
                    begin
                        $error("out_value: expected %h, actual %h", want.val, got_val);
                        error_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("out_last: expected %0d, actual %0d", want.last, m_tlast);
                        error_count++;
                    end
                    if (m_tuser !== want.dropped)
                    begin
                        $error("dropped: expected %0d, actual %0d", want.dropped, m_tuser);
                        error_count++;
                    end
                end
                recv_gap = draw_gap(recv_burst);
            end
            // One long hold-off while the sender keeps offering the next matrix.
            if (hold_request && !hold_done && m_tvalid)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input cfg_word_t val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == stt_pkg::REG_NUM_COLS)
            num_cols_reg = val;
    endtask

    task automatic queue_term(input idx_t row, input idx_t col, input val_t val,
                              input logic last);
        source_term_t t;
        t.row  = row;
        t.col  = col;
        t.val  = val;
        t.last = last;
        @(negedge clk);
        pending_terms.push_back(t);
    endtask

    // One matrix of random terms. A narrow span repeats columns, which tests the
    // ordering within a column; noise puts in random columns, some of which must be dropped.
    task automatic queue_matrix(input int len, input int col_lim, input bit noisy);
        source_term_t t;
        int           span;
        span = ($urandom_range(0, 1) == 1 && col_lim > 4) ? 4 : col_lim;
        @(negedge clk);
        for (int i = 0; i < len; i++)
        begin
            t.row = idx_t'($urandom_range(0, 511));
            if (noisy && $urandom_range(0, 9) == 0)
                t.col = idx_t'($urandom_range(0, 511));
            else
                t.col = idx_t'($urandom_range(1, span));
            t.val  = $urandom();
            t.last = (i == len - 1);
            pending_terms.push_back(t);
        end
    endtask

    task automatic wait_idle();
        while (pending_terms.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int lim;
        int queued;
        int len;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(stt_pkg::REG_NUM_ROWS, 9'd256);
        write_reg(stt_pkg::REG_NUM_COLS, 9'd256);

        // Single term with the most negative value.
        queue_term(9'd1, 9'd1, 32'h8000_0000, 1'b1);
        // Extreme indexes and values, two pairs of terms sharing a column.
        queue_term(9'd256, 9'd256, 32'h7fff_ffff, 1'b0);
        queue_term(9'd1, 9'd256, 32'hffff_ffff, 1'b0);
        queue_term(9'd3, 9'd1, 32'd5, 1'b0);
        queue_term(9'd2, 9'd1, 32'd0, 1'b0);
        queue_term(9'd5, 9'd2, 32'd1, 1'b1);
        // Only the marked term, and it has column zero: the empty-matrix marker.
        queue_term(9'd9, 9'd0, 32'h1234_5678, 1'b1);
        // Columns past the limit are dropped and flagged.
        queue_term(9'd4, 9'd257, 32'h0000_00ff, 1'b0);
        queue_term(9'd6, 9'd511, 32'h5555_aaaa, 1'b0);
        queue_term(9'd7, 9'd3, 32'haaaa_5555, 1'b1);
        // Rows outside the matrix are carried through unchecked.
        queue_term(9'd0, 9'd10, 32'd77, 1'b0);
        queue_term(9'd511, 9'd10, 32'd78, 1'b1);
        wait_idle();

        write_reg(stt_pkg::REG_NUM_ROWS, 9'd1);
        write_reg(stt_pkg::REG_NUM_COLS, 9'd1);
        queue_term(9'd4, 9'd1, 32'hdead_beef, 1'b0);
        queue_term(9'd4, 9'd2, 32'hcafe_f00d, 1'b1);
        wait_idle();

        // A column limit of zero drops everything.
        write_reg(stt_pkg::REG_NUM_COLS, 9'd0);
        queue_term(9'd1, 9'd1, 32'd1, 1'b1);
        wait_idle();

        // A limit above the largest dimension acts as the largest dimension.
        write_reg(stt_pkg::REG_NUM_COLS, 9'd300);
        queue_term(9'd8, 9'd256, 32'd256, 1'b0);
        queue_term(9'd8, 9'd257, 32'd257, 1'b1);
        wait_idle();

        write_reg(REG_SPARE_A, 9'd5);
        write_reg(REG_SPARE_B, 9'd5);
        queue_term(9'd12, 9'd200, 32'h0f0f_0f0f, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(stt_pkg::REG_NUM_ROWS, cfg_word_t'($urandom_range(0, 511)));
            case (ph)
                0: write_reg(stt_pkg::REG_NUM_COLS, 9'd256);
                1: write_reg(stt_pkg::REG_NUM_COLS, cfg_word_t'($urandom_range(1, 255)));
                2: write_reg(stt_pkg::REG_NUM_COLS, 9'd8);
                default: write_reg(stt_pkg::REG_NUM_COLS, 9'd511);
            endcase
            lim = (num_cols_reg > MAX_DIM) ? MAX_DIM : int'(num_cols_reg);
            if (ph == 0)
            begin
                hold_request = 1'b1;
                // Overfills the store, so the tail of the matrix is dropped.
                queue_matrix(70, lim, 1'b0);
            end
            queued = 0;
            while (queued < 42)
            begin
                len = $urandom_range(1, 12);
                queue_matrix(len, lim, 1'b1);
                queued += len;
            end
            wait_idle();
        end

        if (error_count == 0 && expected_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/stt_pkg.sv
design/sparse_triplet_transpose_core.sv
design/stt_checker.sv
tb/sv/testbench.sv
